@@ src/assert_macros.svh @@
// assertion macros used by the demosaic back end
// define NO_ASSERTIONS to compile them out; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_AT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

@@ src/bbdm_pkg.sv @@
// shared types and constants for the bayer bilinear demosaic
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bbdm_pkg;

   localparam int unsigned MaxWidthDefault  = 2048;
   localparam int unsigned MaxHeightDefault = 2048;
   localparam int unsigned PixelWidth       = 8;
   localparam int unsigned CfgDataWidth     = 32;
   localparam int unsigned CfgFieldWidth    = 12;
   localparam int unsigned CfgAddrWidth     = 3;
   localparam int unsigned QueueDepth       = 2;

   localparam logic [CfgFieldWidth-1:0] WidthReset  = 12'd40;
   localparam logic [CfgFieldWidth-1:0] HeightReset = 12'd30;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef enum logic {
      ACT_PIXEL = 1'b0,
      ACT_DRAIN = 1'b1
   } action_type;

   typedef logic [PixelWidth-1:0] pixel_type;

   // per-request command handed from front to back
   typedef struct packed {
      logic      drain;
      logic      emit;
      pixel_type raw;
      logic      row_odd;
      logic      col_odd;
      logic      row_first;
      logic      row_last;
      logic      col_first;
      logic      col_last;
   } item_tag_type;

endpackage

`default_nettype wire

@@ src/bbdm_queue.sv @@
// small command queue between the front and back of the demosaic
// depends on nothing but its parameters
`timescale 1ns / 1ps
`default_nettype none

module bbdm_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty,
   output logic                  full
);

   localparam int unsigned PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      entries_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CountWidth'(DEPTH));
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ src/bbdm_front.sv @@
// front end: takes requests, tracks input and output raster positions,
// drops idle drain ticks and issues commands; uses bbdm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bbdm_front import bbdm_pkg::*; #(
   parameter int unsigned COL_WIDTH = 11,
   parameter int unsigned ROW_WIDTH = 11
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cfg_restart,
   input  wire logic [COL_WIDTH-1:0] width_last,
   input  wire logic [ROW_WIDTH-1:0] height_last,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_action,
   input  wire pixel_type            req_raw_value,
   input  wire logic                 queue_full,
   output logic                      push,
   output logic      [COL_WIDTH-1:0] push_addr,
   output item_tag_type              push_tag
);

   logic [COL_WIDTH-1:0] in_col_ff, in_col_in;
   logic [ROW_WIDTH-1:0] in_row_ff, in_row_in;
   logic [COL_WIDTH-1:0] out_col_ff, out_col_in;
   logic [ROW_WIDTH-1:0] out_row_ff, out_row_in;
   logic [COL_WIDTH-1:0] ocol;
   logic [ROW_WIDTH-1:0] orow;
   logic                 emit;
   logic                 accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      push       = 1'b0;
      push_addr  = in_col_ff;
      emit       = 1'b0;
      orow       = out_row_ff;
      ocol       = out_col_ff;
      if (cfg_restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept) begin
         unique case (action_type'(req_action))
            ACT_PIXEL: begin
               push = 1'b1;
               if (in_col_ff != '0 && in_row_ff != '0) begin
                  emit       = 1'b1;
                  orow       = in_row_ff - ROW_WIDTH'(1);
                  ocol       = in_col_ff - COL_WIDTH'(1);
                  out_row_in = in_row_ff - ROW_WIDTH'(1);
                  out_col_in = in_col_ff;
               end else if (in_col_ff == '0 && in_row_ff > ROW_WIDTH'(1)) begin
                  // column 0 closes out the previous row's last pixel
                  emit       = 1'b1;
                  orow       = in_row_ff - ROW_WIDTH'(2);
                  ocol       = width_last;
                  out_row_in = in_row_ff - ROW_WIDTH'(1);
                  out_col_in = '0;
               end else if (in_col_ff == '0 && in_row_ff == '0) begin
                  // new frame drops whatever is still pending
                  out_row_in = '0;
                  out_col_in = '0;
               end
               if (in_col_ff == width_last) begin
                  in_col_in = '0;
                  in_row_in = (in_row_ff == height_last) ? '0 : in_row_ff + ROW_WIDTH'(1);
               end else begin
                  in_col_in = in_col_ff + COL_WIDTH'(1);
               end
            end
            ACT_DRAIN: begin
               if (in_col_ff == '0 && in_row_ff == '0 &&
                   (out_col_ff != '0 || out_row_ff != '0)) begin
                  push      = 1'b1;
                  emit      = 1'b1;
                  push_addr = (out_col_ff == width_last) ? '0 : out_col_ff + COL_WIDTH'(1);
                  if (out_col_ff == width_last) begin
                     out_col_in = '0;
                     out_row_in = (out_row_ff == height_last) ? '0
                                                              : out_row_ff + ROW_WIDTH'(1);
                  end else begin
                     out_col_in = out_col_ff + COL_WIDTH'(1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      push_tag.drain     = (action_type'(req_action) == ACT_DRAIN);
      push_tag.emit      = emit;
      push_tag.raw       = req_raw_value;
      push_tag.row_odd   = orow[0];
      push_tag.col_odd   = ocol[0];
      push_tag.row_first = (orow == '0);
      push_tag.row_last  = (orow == height_last);
      push_tag.col_first = (ocol == '0);
      push_tag.col_last  = (ocol == width_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

`default_nettype wire

@@ src/bbdm_back.sv @@
// back end: line stores, 3x3 window and bilinear interpolation,
// registered result; uses bbdm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bbdm_back import bbdm_pkg::*; #(
   parameter int unsigned COL_WIDTH = 11,
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 queue_empty,
   input  wire logic [COL_WIDTH-1:0] head_addr,
   input  wire item_tag_type         head_tag,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output pixel_type                 rsp_red,
   output pixel_type                 rsp_green,
   output pixel_type                 rsp_blue,
   output logic                      rsp_row_end,
   output logic                      rsp_frame_end
);

   typedef enum logic [1:0] {
      PH_RED     = 2'b00,
      PH_GREEN_R = 2'b01,
      PH_GREEN_B = 2'b10,
      PH_BLUE    = 2'b11
   } phase_type;

   pixel_type upper_store_ff [MAX_WIDTH];
   pixel_type lower_store_ff [MAX_WIDTH];

   logic                 en;
   logic                 wr_en;
   logic                 s1_valid_ff, s1_valid_in;
   logic [COL_WIDTH-1:0] s1_addr_ff;
   item_tag_type         s1_tag_ff;
   pixel_type            upper_q_ff, lower_q_ff;
   logic                 byp_hit_ff;
   pixel_type            byp_upper_ff, byp_lower_ff;
   pixel_type            upper_rd, lower_rd, bottom;
   pixel_type            window_ff [3][3];
   pixel_type            window_in [3][3];
   logic                 s2_valid_ff, s2_valid_in;
   item_tag_type         s2_tag_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   pixel_type            rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                 rsp_row_end_ff, rsp_frame_end_ff;
   logic [1:0]           rs0, rs2, cs0, cs2;
   pixel_type            ctr, n, s, wv, e, nw, ne, sw, se;
   logic [9:0]           cross_sum, diag_sum;
   logic [8:0]           hpair_sum, vpair_sum;
   pixel_type            red, green, blue;

   // everything moves when the result slot is free or being taken
   assign en    = !rsp_valid_ff || rsp_ready;
   assign pop   = en && !queue_empty;
   assign wr_en = en && s1_valid_ff && !s1_tag_ff.drain;

   // a write in the same cycle as the read of that column is forwarded
   assign upper_rd = byp_hit_ff ? byp_upper_ff : upper_q_ff;
   assign lower_rd = byp_hit_ff ? byp_lower_ff : lower_q_ff;
   assign bottom   = s1_tag_ff.drain ? upper_rd : s1_tag_ff.raw;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_store_ff[s1_addr_ff] <= lower_rd;
         lower_store_ff[s1_addr_ff] <= s1_tag_ff.raw;
      end
      if (pop) begin
         upper_q_ff <= upper_store_ff[head_addr];
         lower_q_ff <= lower_store_ff[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_addr_ff   <= head_addr;
         s1_tag_ff    <= head_tag;
         byp_hit_ff   <= wr_en && (s1_addr_ff == head_addr);
         byp_upper_ff <= lower_rd;
         byp_lower_ff <= s1_tag_ff.raw;
      end
      if (en) begin
         s2_tag_ff <= s1_tag_ff;
      end
      if (en && s2_valid_ff) begin
         rsp_red_ff       <= red;
         rsp_green_ff     <= green;
         rsp_blue_ff      <= blue;
         rsp_row_end_ff   <= s2_tag_ff.col_last;
         rsp_frame_end_ff <= s2_tag_ff.col_last && s2_tag_ff.row_last;
      end
   end

   always_comb begin
      s1_valid_in  = en ? pop : s1_valid_ff;
      s2_valid_in  = en ? (s1_valid_ff && s1_tag_ff.emit) : s2_valid_ff;
      rsp_valid_in = en ? s2_valid_ff : rsp_valid_ff;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            window_in[r][c] = window_ff[r][c];
         end
      end
      if (en && s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            window_in[r][0] = window_ff[r][1];
            window_in[r][1] = window_ff[r][2];
         end
         window_in[0][2] = upper_rd;
         window_in[1][2] = lower_rd;
         window_in[2][2] = bottom;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               window_ff[r][c] <= '0;
            end
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
      end
   end

   // mirror across the edge pixel in each axis
   always_comb begin
      rs0 = s2_tag_ff.row_first ? 2'd2 : 2'd0;
      rs2 = s2_tag_ff.row_last  ? 2'd0 : 2'd2;
      cs0 = s2_tag_ff.col_first ? 2'd2 : 2'd0;
      cs2 = s2_tag_ff.col_last  ? 2'd0 : 2'd2;
      ctr = window_ff[1][1];
      n   = window_ff[rs0][1];
      s   = window_ff[rs2][1];
      wv  = window_ff[1][cs0];
      e   = window_ff[1][cs2];
      nw  = window_ff[rs0][cs0];
      ne  = window_ff[rs0][cs2];
      sw  = window_ff[rs2][cs0];
      se  = window_ff[rs2][cs2];
      cross_sum = 10'(n) + 10'(s) + 10'(e) + 10'(wv);
      diag_sum  = 10'(nw) + 10'(ne) + 10'(sw) + 10'(se);
      hpair_sum = 9'(e) + 9'(wv);
      vpair_sum = 9'(n) + 9'(s);
      unique case (phase_type'({s2_tag_ff.row_odd, s2_tag_ff.col_odd}))
         PH_RED: begin
            red   = ctr;
            green = cross_sum[9:2];
            blue  = diag_sum[9:2];
         end
         PH_GREEN_R: begin
            red   = hpair_sum[8:1];
            green = ctr;
            blue  = vpair_sum[8:1];
         end
         PH_GREEN_B: begin
            red   = vpair_sum[8:1];
            green = ctr;
            blue  = hpair_sum[8:1];
         end
         PH_BLUE: begin
            red   = diag_sum[9:2];
            green = cross_sum[9:2];
            blue  = ctr;
         end
         default: begin
            red   = ctr;
            green = ctr;
            blue  = ctr;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red       = rsp_red_ff;
   assign rsp_green     = rsp_green_ff;
   assign rsp_blue      = rsp_blue_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   `ASSERT_AT(a_emit_reaches_s2, clock, reset, en |=> (s2_valid_ff == $past(s1_valid_ff && s1_tag_ff.emit)))
   `ASSERT_AT(a_rsp_from_s2, clock, reset, $rose(rsp_valid_ff) |-> $past(en && s2_valid_ff))
   `ASSERT_NEVER(a_frame_end_row_end, clock, reset, rsp_valid_ff && rsp_frame_end_ff && !rsp_row_end_ff)

endmodule

`default_nettype wire

@@ src/bayer_bilinear_demosaic.sv @@
// a request is registered in the queue at acceptance, then passes s1 and s2 into
// the result register; pixel (r,c) is output one row plus one pixel after its raw
// sample. throughput: 1 request per cycle unless rsp_ready stalls the output, set
// by one read and one write per cycle on each of the two line stores. reset is
// synchronous: counters, window and pipeline clear, size registers go to 40x30;
// the line stores are not cleared. uses bbdm_pkg, bbdm_front, bbdm_queue, bbdm_back
`timescale 1ns / 1ps
`default_nettype none

module bayer_bilinear_demosaic import bbdm_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = MaxWidthDefault,
   parameter int unsigned MAX_HEIGHT = MaxHeightDefault
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_action,
   input  wire pixel_type               req_raw_value,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output pixel_type                    rsp_red,
   output pixel_type                    rsp_green,
   output pixel_type                    rsp_blue,
   output logic                         rsp_row_end,
   output logic                         rsp_frame_end,
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CfgAddrWidth-1:0] csr_paddr,
   input  wire logic [CfgDataWidth-1:0] csr_pwdata,
   output logic      [CfgDataWidth-1:0] csr_prdata,
   output logic                         csr_pready
);

   function automatic int unsigned last_index(input logic [CfgFieldWidth-1:0] size,
                                              input int unsigned max_size);
      int unsigned v;
      v = 32'(size);
      if (v < 2) begin
         v = 2;
      end else if (v > max_size) begin
         v = max_size;
      end
      return v - 1;
   endfunction

   localparam int unsigned ColWidth   = $clog2(MAX_WIDTH);
   localparam int unsigned RowWidth   = $clog2(MAX_HEIGHT);
   localparam int unsigned QueueWidth = ColWidth + $bits(item_tag_type);
   localparam logic [ColWidth-1:0] WidthLastReset  = ColWidth'(last_index(WidthReset, MAX_WIDTH));
   localparam logic [RowWidth-1:0] HeightLastReset =
      RowWidth'(last_index(HeightReset, MAX_HEIGHT));

   logic [CfgFieldWidth-1:0] frame_width_ff, frame_width_in;
   logic [CfgFieldWidth-1:0] frame_height_ff, frame_height_in;
   logic [ColWidth-1:0]      width_last_ff, width_last_in;
   logic [RowWidth-1:0]      height_last_ff, height_last_in;
   logic                     cfg_write;
   reg_index_type            cfg_index;

   logic                     push, pop, queue_empty, queue_full;
   logic [ColWidth-1:0]      push_addr, head_addr;
   item_tag_type             push_tag, head_tag;
   logic [QueueWidth-1:0]    head_data;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index  = reg_index_type'(csr_paddr[2]);

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      width_last_in   = width_last_ff;
      height_last_in  = height_last_ff;
      if (cfg_write) begin
         unique case (cfg_index)
            REG_FRAME_WIDTH: begin
               frame_width_in = csr_pwdata[CfgFieldWidth-1:0];
               width_last_in  =
                  ColWidth'(last_index(csr_pwdata[CfgFieldWidth-1:0], MAX_WIDTH));
            end
            REG_FRAME_HEIGHT: begin
               frame_height_in = csr_pwdata[CfgFieldWidth-1:0];
               height_last_in  =
                  RowWidth'(last_index(csr_pwdata[CfgFieldWidth-1:0], MAX_HEIGHT));
            end
            default: ;
         endcase
      end
      unique case (cfg_index)
         REG_FRAME_WIDTH:  csr_prdata = CfgDataWidth'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CfgDataWidth'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WidthReset;
         frame_height_ff <= HeightReset;
         width_last_ff   <= WidthLastReset;
         height_last_ff  <= HeightLastReset;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         width_last_ff   <= width_last_in;
         height_last_ff  <= height_last_in;
      end
   end

   bbdm_front #(
      .COL_WIDTH(ColWidth),
      .ROW_WIDTH(RowWidth)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg_restart   (cfg_write),
      .width_last    (width_last_ff),
      .height_last   (height_last_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_raw_value (req_raw_value),
      .queue_full    (queue_full),
      .push          (push),
      .push_addr     (push_addr),
      .push_tag      (push_tag)
   );

   bbdm_queue #(
      .WIDTH(QueueWidth),
      .DEPTH(QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_addr, push_tag}),
      .pop       (pop),
      .pop_data  (head_data),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   assign head_addr = head_data[QueueWidth-1 -: ColWidth];
   assign head_tag  = item_tag_type'(head_data[$bits(item_tag_type)-1:0]);

   bbdm_back #(
      .COL_WIDTH(ColWidth),
      .MAX_WIDTH(MAX_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .head_addr     (head_addr),
      .head_tag      (head_tag),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire
